[hw/rtl/bouncing_sprite_motion_step_assert.svh]
// Assertion macros used by the bouncing sprite RTL.
`ifndef BOUNCING_SPRITE_MOTION_STEP_ASSERT_SVH
`define BOUNCING_SPRITE_MOTION_STEP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSMS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsms assertion failed");

// Next-cycle implication, checked out of reset.
`define BSMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsms assertion failed");

`endif

[hw/rtl/bsms_pkg.sv]
// Types and constants of the bouncing sprite motion step.
package bsms_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HORIZONTAL_SPEED = 2'd0,
        CFG_GRAVITY_TENTHS   = 2'd1,
        CFG_WALL_RIGHT       = 2'd2,
        CFG_WALL_BOTTOM      = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [5:0] HSPEED_RESET  = 6'd7;
    localparam logic [5:0] GRAVITY_RESET = 6'd5;
    localparam logic [9:0] WALL_R_RESET  = 10'd350;
    localparam logic [9:0] WALL_B_RESET  = 10'd200;

    // Tile grid (tile size is a power of two)
    localparam int          TILE_SIZE     = 8;
    localparam int          TILE_SHIFT    = $clog2(TILE_SIZE);
    localparam int          SCREEN_W_PX   = 640;
    localparam logic [15:0] TILES_PER_ROW = 16'(SCREEN_W_PX / TILE_SIZE);
    localparam logic [15:0] VRAM_BASE     = 16'hA000;

    // Graphics control word: palette in the top nibble, enable at bit 4
    localparam logic [11:0] GFX_LOW_BITS = 12'h010;

    // Palette rotation
    localparam logic [3:0] PALETTE_LAST = 4'd13;

    // n / 10 for 16-bit unsigned n: (n * 52429) >> 19
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Speed limits
    localparam logic signed [15:0] VSPEED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] VSPEED_MIN = 16'sh8000;
    localparam logic signed [7:0]  HSPEED_MAX = 8'sh7F;
    localparam logic signed [7:0]  HSPEED_MIN = 8'sh80;

endpackage

[hw/rtl/bsms_motion.sv]
// Next-state logic of one frame: gravity, vertical bounce, horizontal move, palette.
module bsms_motion
    import bsms_pkg::*;
#(
    parameter int POSITION_WIDTH = 12
) (
    input  logic signed [POSITION_WIDTH-1:0] pos_x,
    input  logic signed [POSITION_WIDTH-1:0] pos_y,
    input  logic signed [7:0]                speed_x,
    input  logic signed [15:0]               speed_y,
    input  logic [3:0]                       palette,
    input  logic [5:0]                       gravity_tenths,
    input  logic [9:0]                       right_limit,
    input  logic [9:0]                       bottom_limit,
    output logic signed [POSITION_WIDTH-1:0] pos_x_next,
    output logic signed [POSITION_WIDTH-1:0] pos_y_next,
    output logic signed [7:0]                speed_x_next,
    output logic signed [15:0]               speed_y_next,
    output logic [3:0]                       palette_next
);

    // Sum width: holds a position plus a speed step without overflow
    localparam int SW = ((POSITION_WIDTH > 13) ? POSITION_WIDTH : 13) + 2;
    localparam logic signed [SW-1:0] POS_MAX = SW'(2 ** (POSITION_WIDTH - 1) - 1);
    localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);

    function automatic logic signed [POSITION_WIDTH-1:0] pos_sat(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] r;
        begin
            if (v > POS_MAX) begin
                r = POS_MAX;
            end else if (v < POS_MIN) begin
                r = POS_MIN;
            end else begin
                r = v;
            end
            return r[POSITION_WIDTH-1:0];
        end
    endfunction

    logic signed [16:0]               vy_sum;
    logic signed [15:0]               vy_sat;
    logic signed [15:0]               vy_neg;
    logic [15:0]                      vy_mag;
    logic [31:0]                      vy_prod;
    logic [12:0]                      vy_quo;
    logic signed [13:0]               step_y;
    logic signed [POSITION_WIDTH-1:0] py1;
    logic signed [POSITION_WIDTH-1:0] py2;
    logic                             bounce_y;
    logic signed [POSITION_WIDTH-1:0] px1;
    logic                             bounce_x;
    logic signed [7:0]                sx_neg;

    // Gravity; speed only grows here, so only the upper limit applies
    assign vy_sum = 17'(speed_y) + $signed({11'b0, gravity_tenths});
    assign vy_sat = (vy_sum > 17'sd32767) ? VSPEED_MAX : vy_sum[15:0];

    // Truncating divide by ten through the magnitude
    assign vy_mag  = vy_sat[15] ? (~vy_sat + 16'd1) : vy_sat;
    assign vy_prod = 32'(vy_mag) * DIV10_MUL;
    assign vy_quo  = vy_prod[DIV10_SHIFT +: 13];
    assign step_y  = vy_sat[15] ? -$signed({1'b0, vy_quo}) : $signed({1'b0, vy_quo});

    // First vertical move and wall test
    assign py1 = pos_sat(SW'(pos_y) + SW'(step_y));
    assign bounce_y = (SW'(py1) > $signed(SW'(bottom_limit))) || py1[POSITION_WIDTH-1];

    // Bounce: negated speed divides to the negated quotient, even at the limit
    assign vy_neg = (vy_sat == VSPEED_MIN) ? VSPEED_MAX : -vy_sat;
    assign py2    = pos_sat(SW'(py1) - SW'(step_y));

    assign speed_y_next = bounce_y ? vy_neg : vy_sat;
    assign pos_y_next   = bounce_y ? py2 : py1;

    // Horizontal move; a flip applies from the next frame
    assign px1      = pos_sat(SW'(pos_x) + SW'(speed_x));
    assign bounce_x = (SW'(px1) > $signed(SW'(right_limit))) || px1[POSITION_WIDTH-1];
    assign sx_neg   = (speed_x == HSPEED_MIN) ? HSPEED_MAX : -speed_x;

    assign pos_x_next   = px1;
    assign speed_x_next = bounce_x ? sx_neg : speed_x;

    // Palette rotates up when moving left, down otherwise
    always_comb begin
        if (speed_x_next[7]) begin
            palette_next = (palette >= PALETTE_LAST) ? 4'd0 : palette + 4'd1;
        end else begin
            palette_next = (palette == 4'd0) ? PALETTE_LAST : palette - 4'd1;
        end
    end

endmodule

[hw/rtl/bouncing_sprite_motion_step.sv]
// Top level of the bouncing sprite motion step: state, tile mapping and stream ports.
//
// Each input word with frame_tick set advances the ball one frame and yields one
// output word; a word with frame_tick clear is taken and dropped. The block takes
// one word per clock unless a stalled output holds s_tready low. The frame update
// (one 16x16 reciprocal multiply for the divide by ten, then the move and bounce
// adders) closes its loop through the state registers at the edge that takes the
// word, and the tile address and scroll offsets are formed from the updated state
// and loaded into the output register once it is free, which raises m_tvalid. While
// a result waits for m_tready one more frame tick can be taken; after that s_tready
// stays low until the output word moves. Configuration writes apply at once; writing
// horizontal_speed also reloads the current x speed.
module bouncing_sprite_motion_step
    import bsms_pkg::*;
#(
    parameter int POSITION_WIDTH = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] frame_tick, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [15:0] vram_address, [19:16] scroll_x_offset,
                                    // [23:20] scroll_y_offset, [39:24] gfx_control,
                                    // [51:40] ball_x, [63:52] ball_y
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    `include "bouncing_sprite_motion_step_assert.svh"

    localparam int PW = POSITION_WIDTH;
    localparam int CW = POSITION_WIDTH + 1;

    // Configuration registers
    logic [5:0] hspeed_reg;
    logic [5:0] gravity_reg;
    logic [9:0] wall_right_reg;
    logic [9:0] wall_bottom_reg;

    // Motion state
    logic signed [PW-1:0] pos_x_reg,   pos_x_next;
    logic signed [PW-1:0] pos_y_reg,   pos_y_next;
    logic signed [7:0]    speed_x_reg, speed_x_next;
    logic signed [15:0]   speed_y_reg, speed_y_next;
    logic [3:0]           palette_reg, palette_next;

    // Pipeline control and output register
    logic        st_valid_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [63:0] m_tdata_next;
    logic        out_ready;
    logic        tick_accept;

    assign out_ready   = !m_tvalid_reg || m_tready;
    assign s_tready    = !st_valid_reg || out_ready;
    assign tick_accept = s_tvalid && s_tready && s_tdata[0];
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;

    // Frame update
    bsms_motion #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_motion (
        .pos_x         (pos_x_reg),
        .pos_y         (pos_y_reg),
        .speed_x       (speed_x_reg),
        .speed_y       (speed_y_reg),
        .palette       (palette_reg),
        .gravity_tenths(gravity_reg),
        .right_limit   (wall_right_reg),
        .bottom_limit  (wall_bottom_reg),
        .pos_x_next    (pos_x_next),
        .pos_y_next    (pos_y_next),
        .speed_x_next  (speed_x_next),
        .speed_y_next  (speed_y_next),
        .palette_next  (palette_next)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hspeed_reg      <= HSPEED_RESET;
            gravity_reg     <= GRAVITY_RESET;
            wall_right_reg  <= WALL_R_RESET;
            wall_bottom_reg <= WALL_B_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HORIZONTAL_SPEED: hspeed_reg      <= cfg_wdata[5:0];
                CFG_GRAVITY_TENTHS:   gravity_reg     <= cfg_wdata[5:0];
                CFG_WALL_RIGHT:       wall_right_reg  <= cfg_wdata;
                CFG_WALL_BOTTOM:      wall_bottom_reg <= cfg_wdata;
            endcase
        end
    end

    // Motion state: advances on each accepted tick; a horizontal_speed write reloads the x speed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            speed_x_reg <= $signed({2'b0, HSPEED_RESET});
            speed_y_reg <= '0;
            palette_reg <= '0;
        end else begin
            if (tick_accept) begin
                pos_x_reg   <= pos_x_next;
                pos_y_reg   <= pos_y_next;
                speed_y_reg <= speed_y_next;
                palette_reg <= palette_next;
            end
            if (cfg_we && (cfg_index_t'(cfg_index) == CFG_HORIZONTAL_SPEED)) begin
                speed_x_reg <= $signed({2'b0, cfg_wdata[5:0]});
            end else if (tick_accept) begin
                speed_x_reg <= speed_x_next;
            end
        end
    end

    // Tile mapping from the updated state
    logic signed [CW-1:0] nx, ny, adj_x, adj_y, col, row;
    logic [3:0]           shift_x, shift_y;
    logic [15:0]          col_w, row_w, vram_addr;
    logic [15:0]          bx_w, by_w;

    always_comb begin
        nx    = CW'(pos_x_reg) + CW'(TILE_SIZE - 1);
        ny    = CW'(pos_y_reg) + CW'(TILE_SIZE - 1);
        // round toward zero for negative sums
        adj_x = nx + (nx[CW-1] ? CW'(TILE_SIZE - 1) : CW'(0));
        adj_y = ny + (ny[CW-1] ? CW'(TILE_SIZE - 1) : CW'(0));
        col   = adj_x >>> TILE_SHIFT;
        row   = adj_y >>> TILE_SHIFT;
        shift_x = 4'((col <<< TILE_SHIFT) - CW'(pos_x_reg));
        shift_y = 4'((row <<< TILE_SHIFT) - CW'(pos_y_reg));
        col_w = 16'(col);
        row_w = 16'(row);
        vram_addr = VRAM_BASE + 16'(row_w * TILES_PER_ROW) + col_w;
        bx_w = 16'(pos_x_reg);
        by_w = 16'(pos_y_reg);
        m_tdata_next = {by_w[11:0], bx_w[11:0], palette_reg, GFX_LOW_BITS,
                        shift_y, shift_x, vram_addr};
    end

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (tick_accept) begin
                st_valid_reg <= 1'b1;
            end else if (out_ready) begin
                st_valid_reg <= 1'b0;
            end
            if (out_ready) begin
                m_tvalid_reg <= st_valid_reg;
            end
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (out_ready && st_valid_reg) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Checks
    `BSMS_ASSERT_NOW(a_palette_range, aclk, aresetn, 1'b1, palette_reg <= PALETTE_LAST)
    `BSMS_ASSERT_NEXT(a_tick_fills_stage, aclk, aresetn, tick_accept, st_valid_reg)
    `BSMS_ASSERT_NEXT(a_tick_moves_palette, aclk, aresetn, tick_accept, !$stable(palette_reg))
    `BSMS_ASSERT_NEXT(a_idle_word_keeps_pos, aclk, aresetn,
                      s_tvalid && s_tready && !s_tdata[0] && !st_valid_reg,
                      $stable(pos_x_reg) && $stable(pos_y_reg) && !st_valid_reg)
    `BSMS_ASSERT_NOW(a_out_from_stage, aclk, aresetn, $rose(m_tvalid_reg), $past(st_valid_reg))
    `BSMS_ASSERT_NOW(a_speed_x_magnitude, aclk, aresetn, 1'b1,
                     ((speed_x_reg == $signed({2'b0, hspeed_reg}))
                      || (speed_x_reg == -$signed({2'b0, hspeed_reg}))))

endmodule

[tb/tb_bouncing_sprite_motion_step.sv]
// Self-checking testbench for the bouncing sprite motion step.
`timescale 1ns / 100ps

module tb_bouncing_sprite_motion_step;
    import bsms_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_TICKS  = 660;
    localparam int SETTLE_CYCLES = 4;
    localparam int POS_MAX       = 2047;
    localparam int POS_MIN       = -2048;

    // One output word, split into its fields
    typedef struct {
        logic [15:0] vram;
        logic [3:0]  shift_x;
        logic [3:0]  shift_y;
        logic [15:0] gfx;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } frame_out_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;    // [0] frame_tick, [7:1] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;             // [15:0] vram_address, [19:16] scroll_x_offset,
                                      // [23:20] scroll_y_offset, [39:24] gfx_control,
                                      // [51:40] ball_x, [63:52] ball_y
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_HORIZONTAL_SPEED;
    logic [9:0]  cfg_wdata = 10'd0;

    // Ball state and register copies for prediction
    int reg_hspeed  = HSPEED_RESET;
    int reg_gravity = GRAVITY_RESET;
    int reg_wall_r  = WALL_R_RESET;
    int reg_wall_b  = WALL_B_RESET;
    int cur_x       = 0;
    int cur_y       = 0;
    int vel_x       = HSPEED_RESET;
    int vel_y       = 0;
    int pal         = 0;

    frame_out_t pending_frames[$];

    bit no_gaps        = 1'b0;
    int err_count      = 0;
    int cycle_count    = 0;
    int ticks_sent     = 0;
    int blanks_sent    = 0;
    int frames_checked = 0;
    int settings_used  = 0;

    bouncing_sprite_motion_step u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, pending_frames.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stalls
    always @(negedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(99) >= 12);
    end

    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the ball one frame and queue the word it should produce
    task automatic predict_frame();
        int row;
        int col;
        int addr;
        int dx;
        int dy;
        frame_out_t f;
        // vertical move, bounce on top or bottom wall
        vel_y = clamp_to(vel_y + reg_gravity, -32768, 32767);
        cur_y = clamp_to(cur_y + vel_y / 10, POS_MIN, POS_MAX);
        if (cur_y > reg_wall_b || cur_y < 0) begin
            vel_y = clamp_to(-vel_y, -32768, 32767);
            cur_y = clamp_to(cur_y + vel_y / 10, POS_MIN, POS_MAX);
        end
        // horizontal move; reversal applies next frame
        cur_x = clamp_to(cur_x + vel_x, POS_MIN, POS_MAX);
        if (cur_x > reg_wall_r || cur_x < 0)
            vel_x = clamp_to(-vel_x, -128, 127);
        // tile index rounds up, truncating toward zero
        row  = (cur_y + TILE_SIZE - 1) / TILE_SIZE;
        col  = (cur_x + TILE_SIZE - 1) / TILE_SIZE;
        addr = int'(VRAM_BASE) + row * int'(TILES_PER_ROW) + col;
        dx   = col * TILE_SIZE - cur_x;
        dy   = row * TILE_SIZE - cur_y;
        // palette walks up while moving left, down otherwise
        if (vel_x < 0) begin
            pal = pal + 1;
            if (pal > int'(PALETTE_LAST))
                pal = 0;
        end else if (pal == 0) begin
            pal = PALETTE_LAST;
        end else begin
            pal = pal - 1;
        end
        f.vram    = addr[15:0];
        f.shift_x = dx[3:0];
        f.shift_y = dy[3:0];
        f.gfx     = {pal[3:0], GFX_LOW_BITS};
        f.pos_x   = cur_x[11:0];
        f.pos_y   = cur_y[11:0];
        pending_frames.push_back(f);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // Compare each output word with the oldest predicted frame
    always @(posedge aclk) begin
        frame_out_t f;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                $error("output word 0x%h with no frame outstanding", m_tdata);
                err_count++;
            end else begin
                f = pending_frames.pop_front();
                check_field("vram_address",    f.vram,    m_tdata[15:0]);
                check_field("scroll_x_offset", f.shift_x, m_tdata[19:16]);
                check_field("scroll_y_offset", f.shift_y, m_tdata[23:20]);
                check_field("gfx_control",     f.gfx,     m_tdata[39:24]);
                check_field("ball_x",          f.pos_x,   m_tdata[51:40]);
                check_field("ball_y",          f.pos_y,   m_tdata[63:52]);
                frames_checked++;
            end
        end
    end

    // Send one input word; called and returns at a falling edge
    task automatic send_word(input bit tick);
        if (!no_gaps && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        do @(posedge aclk); while (!s_tready);
        if (tick) begin
            predict_frame();
            ticks_sent++;
        end else begin
            blanks_sent++;
        end
        @(negedge aclk);
    endtask

    // Stop sending, let every frame come out, then wait for the block to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= 10'(value);
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HORIZONTAL_SPEED: begin
                reg_hspeed = value & 'h3F;
                vel_x      = reg_hspeed;
            end
            CFG_GRAVITY_TENTHS: reg_gravity = value & 'h3F;
            CFG_WALL_RIGHT:     reg_wall_r  = value & 'h3FF;
            CFG_WALL_BOTTOM:    reg_wall_b  = value & 'h3FF;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_all(input int hspeed, input int gravity, input int wall_r,
                           input int wall_b);
        write_reg(CFG_HORIZONTAL_SPEED, hspeed);
        write_reg(CFG_GRAVITY_TENTHS, gravity);
        write_reg(CFG_WALL_RIGHT, wall_r);
        write_reg(CFG_WALL_BOTTOM, wall_b);
        settings_used++;
    endtask

    function automatic int pick_setting(int hi);
        case ($urandom_range(3))
            0:       return 0;
            1:       return hi;
            default: return $urandom_range(hi);
        endcase
    endfunction

    // Frames straight out of reset, with a blank word among them
    task automatic test_reset_values();
        settings_used++;
        repeat (4) send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        drain();
    endtask

    // Register extremes: zero speed and gravity, hard side walls, ball pushed to negative x
    task automatic test_register_extremes();
        set_all(0, 0, 0, 0);
        repeat (3) send_word(1'b1);
        drain();
        set_all(63, 63, 0, 1023);
        repeat (5) send_word(1'b1);
        drain();
        set_all(63, 63, 1023, 0);
        repeat (2) send_word(1'b1);
        send_word(1'b0);
        repeat (2) send_word(1'b1);
        drain();
        set_all(HSPEED_RESET, GRAVITY_RESET, WALL_R_RESET, WALL_B_RESET);
        send_word(1'b0);
        repeat (3) send_word(1'b1);
        drain();
    endtask

    // Random settings, each followed by a run of mostly frame ticks
    task automatic test_random_frames();
        int goal;
        int run_len;
        int phase;
        goal  = ticks_sent + RANDOM_TICKS;
        phase = 0;
        while (ticks_sent < goal) begin
            if (phase == 0) begin
                set_all(pick_setting(63), pick_setting(63), pick_setting(1023),
                        pick_setting(1023));
            end else begin
                if ($urandom_range(1)) write_reg(CFG_HORIZONTAL_SPEED, pick_setting(63));
                if ($urandom_range(1)) write_reg(CFG_GRAVITY_TENTHS, pick_setting(63));
                if ($urandom_range(1)) write_reg(CFG_WALL_RIGHT, pick_setting(1023));
                if ($urandom_range(1)) write_reg(CFG_WALL_BOTTOM, pick_setting(1023));
                settings_used++;
            end
            // one long run with neither side pausing
            no_gaps = (phase == 4);
            run_len = no_gaps ? 150 : $urandom_range(10, 60);
            repeat (run_len) send_word($urandom_range(99) >= 8);
            drain();
            no_gaps = 1'b0;
            phase++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_register_extremes();
        test_random_frames();

        $display("Sent %0d frame ticks and %0d blank words under %0d register settings;",
                 ticks_sent, blanks_sent, settings_used);
        $display("checked %0d output words field by field.", frames_checked);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
